// File: src/qr_modified_gram_schmidt_core_defines.svh
// ----------------------------------------------------------------------------
// QR modified Gram-Schmidt core: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QR_MODIFIED_GRAM_SCHMIDT_CORE_DEFINES_SVH
`define QR_MODIFIED_GRAM_SCHMIDT_CORE_DEFINES_SVH

// same-cycle implication
`define QRMGS_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("qrmgs assertion failed");

// next-cycle implication
`define QRMGS_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("qrmgs assertion failed");

`endif

// File: src/qrmgs_pkg.sv
// ----------------------------------------------------------------------------
// qrmgs_pkg
// Types and constants shared by the QR modified Gram-Schmidt core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qrmgs_pkg;

    localparam int ROW_FW     = 5;   // holds row counts up to 16
    localparam int COL_FW     = 4;   // holds column counts up to 8
    localparam int LIDX_FW    = 8;   // load index up to 128 entries
    localparam int TOL_W      = 16;
    localparam int SQRT_STEPS = 32;  // two radicand bits per step, 64-bit sum

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_TOL  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_REJECT,
        S_N_RD,
        S_N_WAIT,
        S_N_SQ,
        S_N_ACC,
        S_SQRT,
        S_NORM,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_DIV,
        S_Q_WR,
        S_P_RD,
        S_P_WAIT,
        S_P_MUL,
        S_P_ACC,
        S_RKJ,
        S_U_RD,
        S_U_WAIT,
        S_U_MUL,
        S_U_WR,
        S_E_RD,
        S_E_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ,
        OP_ACC_SQ,
        OP_SQRT,
        OP_NORM,
        OP_DIV,
        OP_Q_WR,
        OP_MUL_QW,
        OP_ACC_P,
        OP_RKJ,
        OP_MUL_QR,
        OP_W_WR,
        OP_EMIT,
        OP_REJECT
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                first;
        logic                last;
        logic                mat;
        logic [ROW_FW-1:0]   row;
        logic [COL_FW-1:0]   wcol;
        logic [COL_FW-1:0]   qcol;
        logic [LIDX_FW-1:0]  lidx;
    } cmd_t;

    typedef struct packed {
        logic [ROW_FW-1:0] rows;
        logic [COL_FW-1:0] cols;
        logic [TOL_W-1:0]  tol;
    } cfg_t;

    typedef struct packed {
        logic skip;
    } stat_t;

endpackage

// File: src/qrmgs_ram.sv
// ----------------------------------------------------------------------------
// qrmgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrmgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/qrmgs_ctrl.sv
// ----------------------------------------------------------------------------
// qrmgs_ctrl
// Sequencer: load count, row/column loops, iteration counts, emission order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrmgs_ctrl #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             last_element,
    input  qrmgs_pkg::cfg_t  cfg,
    input  qrmgs_pkg::stat_t stat,
    output logic             busy,
    output qrmgs_pkg::cmd_t  cmd
);

    import qrmgs_pkg::*;

    localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DIV_STEPS = 32 + FRAC_BITS + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int LC_W      = $clog2(MAX_ROWS * MAX_COLS + 1);

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   i_reg, i_next;
    logic [COL_W-1:0]   j_reg, j_next;
    logic [COL_W-1:0]   k_reg, k_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [LC_W-1:0]    lcnt_reg, lcnt_next;
    logic               rph_reg, rph_next;

    logic               accept;
    logic               load_ok;
    logic               reject;
    logic               i_last;
    logic               i_nlast;
    logic               j_last;
    logic               k_last;
    logic [LIDX_FW-1:0] total;

    assign accept  = start && (state_reg == S_IDLE);
    assign total   = LIDX_FW'(cfg.rows) * LIDX_FW'(cfg.cols);
    assign load_ok = LIDX_FW'(lcnt_reg) < total;
    assign reject  = ROW_FW'(cfg.cols) > cfg.rows;
    assign i_last  = ROW_FW'(i_reg) == (cfg.rows - ROW_FW'(1));
    assign i_nlast = ROW_FW'(i_reg) == (ROW_FW'(cfg.cols) - ROW_FW'(1));
    assign j_last  = COL_FW'(j_reg) == (cfg.cols - COL_FW'(1));
    assign k_last  = COL_FW'(k_reg) == (cfg.cols - COL_FW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            step_reg  <= '0;
            lcnt_reg  <= '0;
            rph_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            lcnt_reg  <= lcnt_next;
            rph_reg   <= rph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        lcnt_next  = lcnt_reg;
        rph_next   = rph_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (load_ok)
                    begin
                        lcnt_next = lcnt_reg + 1'b1;
                    end
                    if (last_element)
                    begin
                        lcnt_next  = '0;
                        i_next     = '0;
                        j_next     = '0;
                        k_next     = '0;
                        rph_next   = 1'b0;
                        state_next = reject ? S_REJECT : S_N_RD;
                    end
                end
            end
            S_REJECT: state_next = S_IDLE;
            S_N_RD:   state_next = S_N_WAIT;
            S_N_WAIT: state_next = S_N_SQ;
            S_N_SQ:   state_next = S_N_ACC;
            S_N_ACC:
            begin
                if (i_last)
                begin
                    i_next     = '0;
                    step_next  = '0;
                    state_next = S_SQRT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_N_RD;
                end
            end
            S_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_NORM:
            begin
                i_next     = '0;
                state_next = S_Q_RD;
            end
            S_Q_RD:   state_next = S_Q_WAIT;
            S_Q_WAIT:
            begin
                step_next  = '0;
                state_next = stat.skip ? S_Q_WR : S_Q_DIV;
            end
            S_Q_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_Q_WR;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_Q_WR:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (k_last)
                    begin
                        j_next     = '0;
                        rph_next   = 1'b0;
                        state_next = S_E_RD;
                    end
                    else
                    begin
                        j_next     = k_reg + 1'b1;
                        state_next = S_P_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_Q_RD;
                end
            end
            S_P_RD:   state_next = S_P_WAIT;
            S_P_WAIT: state_next = S_P_MUL;
            S_P_MUL:  state_next = S_P_ACC;
            S_P_ACC:
            begin
                if (i_last)
                begin
                    i_next     = '0;
                    state_next = S_RKJ;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_P_RD;
                end
            end
            S_RKJ:    state_next = S_U_RD;
            S_U_RD:   state_next = S_U_WAIT;
            S_U_WAIT: state_next = S_U_MUL;
            S_U_MUL:  state_next = S_U_WR;
            S_U_WR:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (j_last)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_N_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_P_RD;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_U_RD;
                end
            end
            S_E_RD:   state_next = S_E_OUT;
            S_E_OUT:
            begin
                state_next = S_E_RD;
                if (j_last)
                begin
                    j_next = '0;
                    if (rph_reg)
                    begin
                        if (i_nlast)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else if (i_last)
                    begin
                        rph_next = 1'b1;
                        i_next   = '0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = state_reg != S_IDLE;
        cmd        = '0;
        cmd.op     = OP_NOP;
        cmd.row    = ROW_FW'(i_reg);
        cmd.wcol   = COL_FW'(k_reg);
        cmd.qcol   = COL_FW'(k_reg);
        cmd.lidx   = LIDX_FW'(lcnt_reg);
        cmd.first  = i_reg == '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && load_ok)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_REJECT: cmd.op = OP_REJECT;
            S_N_SQ:   cmd.op = OP_SQ;
            S_N_ACC:  cmd.op = OP_ACC_SQ;
            S_SQRT:
            begin
                cmd.op    = OP_SQRT;
                cmd.first = step_reg == '0;
            end
            S_NORM:   cmd.op = OP_NORM;
            S_Q_DIV:
            begin
                cmd.op    = OP_DIV;
                cmd.first = step_reg == '0;
            end
            S_Q_WR:   cmd.op = OP_Q_WR;
            S_P_RD, S_P_WAIT, S_U_RD, S_U_WAIT:
            begin
                cmd.wcol = COL_FW'(j_reg);
            end
            S_P_MUL:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.op   = OP_MUL_QW;
            end
            S_P_ACC:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.op   = OP_ACC_P;
            end
            S_RKJ:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.op   = OP_RKJ;
            end
            S_U_MUL:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.op   = OP_MUL_QR;
            end
            S_U_WR:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.op   = OP_W_WR;
            end
            S_E_RD:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.qcol = COL_FW'(j_reg);
            end
            S_E_OUT:
            begin
                cmd.wcol = COL_FW'(j_reg);
                cmd.qcol = COL_FW'(j_reg);
                cmd.op   = OP_EMIT;
                cmd.mat  = rph_reg;
                cmd.last = rph_reg && j_last && i_nlast;
            end
            default: ;
        endcase
    end

endmodule

// File: src/qrmgs_dp.sv
// ----------------------------------------------------------------------------
// qrmgs_dp
// Datapath: matrix stores, squarer/MAC, bit-serial root and divider, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qrmgs_dp #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  qrmgs_pkg::cmd_t    cmd,
    input  qrmgs_pkg::cfg_t    cfg,
    input  logic signed [31:0] element_value,
    output qrmgs_pkg::stat_t   stat,
    output logic               result_valid,
    output logic signed [31:0] result_value,
    output logic               which_matrix,
    output logic [2:0]         row_index,
    output logic [1:0]         col_index,
    output logic               last_result,
    output logic               status
);

    import qrmgs_pkg::*;

    localparam int W_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int R_DEPTH = MAX_COLS * MAX_COLS;
    localparam int RA_W    = (R_DEPTH > 1) ? $clog2(R_DEPTH) : 1;
    localparam int NUM_W   = 32 + FRAC_BITS + 1;
    localparam int D_W     = 67 - FRAC_BITS;

    function automatic logic [63:0] scale_mag(input logic [63:0] v);
        logic [63:0] mag;
        mag = v[63] ? (~v + 64'd1) : v;
        return (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [31:0] res;
        if (neg)
        begin
            res = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(~mag + 64'd1);
        end
        else
        begin
            res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
        return res;
    endfunction

    // memories
    logic [WA_W-1:0]  w_rd_addr, w_wr_addr, q_addr;
    logic [RA_W-1:0]  r_rd_addr, r_wr_addr;
    logic             w_wr_en, q_wr_en, r_wr_en;
    logic [31:0]      w_wr_data, q_wr_data, r_wr_data;
    logic [31:0]      w_rd, q_rd, r_rd;

    // arithmetic state
    logic [63:0]        sq_reg, sum_reg, x_reg;
    logic [33:0]        rem_reg;
    logic [31:0]        root_reg, norm_reg;
    logic [NUM_W-1:0]   dq_reg;
    logic [31:0]        drem_reg;
    logic               neg_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic [31:0]        rkj_reg;
    logic               skip_reg, skip_next;
    logic               valid_reg, valid_next;
    logic [31:0]        value_reg;
    logic               which_reg, last_reg, status_reg;
    logic [2:0]         row_reg;
    logic [1:0]         col_reg;

    logic [31:0]        wmag;
    logic [63:0]        sq_full;
    logic [64:0]        sum_add;
    logic [63:0]        xs;
    logic [33:0]        rs;
    logic [31:0]        rt;
    logic [35:0]        remsh, trial;
    logic               sq_ge;
    logic [31:0]        norm_c;
    logic [NUM_W-1:0]   dsrc;
    logic [31:0]        drs;
    logic [32:0]        dsh;
    logic               d_ge;
    logic [31:0]        qsat, rkj_c, w_upd;
    logic [63:0]        pm;
    logic signed [D_W-1:0] p_s, wext, diff;
    logic [D_W-1:0]     dmag;
    logic               lower;

    assign w_rd_addr = WA_W'(cmd.row) * WA_W'(cfg.cols) + WA_W'(cmd.wcol);
    assign w_wr_addr = (cmd.op == OP_LOAD) ? WA_W'(cmd.lidx) : w_rd_addr;
    assign w_wr_en   = (cmd.op == OP_LOAD) || (cmd.op == OP_W_WR);
    assign w_wr_data = (cmd.op == OP_LOAD) ? element_value : w_upd;
    assign q_addr    = WA_W'(cmd.row) * WA_W'(MAX_COLS) + WA_W'(cmd.qcol);
    assign q_wr_en   = cmd.op == OP_Q_WR;
    assign q_wr_data = skip_reg ? 32'd0 : qsat;
    assign r_rd_addr = RA_W'(cmd.row) * RA_W'(MAX_COLS) + RA_W'(cmd.wcol);
    assign r_wr_addr = RA_W'(cmd.qcol) * RA_W'(MAX_COLS) + RA_W'(cmd.wcol);
    assign r_wr_en   = (cmd.op == OP_NORM) || (cmd.op == OP_RKJ);
    assign r_wr_data = (cmd.op == OP_NORM) ? norm_c : rkj_c;

    qrmgs_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_work_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (w_wr_addr),
        .wr_data (w_wr_data),
        .rd_addr (w_rd_addr),
        .rd_data (w_rd)
    );

    qrmgs_ram #(.WIDTH(32), .DEPTH(W_DEPTH)) u_q_ram (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_addr),
        .wr_data (q_wr_data),
        .rd_addr (q_addr),
        .rd_data (q_rd)
    );

    qrmgs_ram #(.WIDTH(32), .DEPTH(R_DEPTH)) u_r_ram (
        .clk     (clk),
        .wr_en   (r_wr_en),
        .wr_addr (r_wr_addr),
        .wr_data (r_wr_data),
        .rd_addr (r_rd_addr),
        .rd_data (r_rd)
    );

    always_comb
    begin
        wmag    = w_rd[31] ? (~w_rd + 32'd1) : w_rd;
        sq_full = 64'(wmag) * 64'(wmag);
        sum_add = {1'b0, (cmd.first ? 64'd0 : sum_reg)} + {1'b0, sq_reg};

        // one result bit of the floor square root per step
        xs    = cmd.first ? sum_reg : x_reg;
        rs    = cmd.first ? 34'd0 : rem_reg;
        rt    = cmd.first ? 32'd0 : root_reg;
        remsh = {rs, xs[63:62]};
        trial = {2'b00, rt, 2'b01};
        sq_ge = remsh >= trial;

        norm_c = root_reg[31] ? 32'h7FFF_FFFF : root_reg;

        // restoring divide of (|a| << F) + norm/2 by norm, one bit per step
        dsrc = cmd.first ? ((NUM_W'(wmag) << FRAC_BITS) + NUM_W'(norm_reg[31:1])) : dq_reg;
        drs  = cmd.first ? 32'd0 : drem_reg;
        dsh  = {drs, dsrc[NUM_W-1]};
        d_ge = dsh >= {1'b0, norm_reg};
        qsat = sat_mag(neg_reg, 64'(dq_reg));

        rkj_c = sat_mag(acc_reg[63], scale_mag(acc_reg));

        pm    = scale_mag(prod_reg);
        p_s   = prod_reg[63] ? -$signed({1'b0, pm[D_W-2:0]}) : $signed({1'b0, pm[D_W-2:0]});
        wext  = D_W'($signed(w_rd));
        diff  = wext - p_s;
        dmag  = diff[D_W-1] ? (~diff + 1'b1) : diff;
        w_upd = sat_mag(diff[D_W-1], 64'(dmag));

        lower = COL_FW'(cmd.row) > cmd.wcol;

        skip_next = skip_reg;
        if (cmd.op == OP_NORM)
        begin
            skip_next = (norm_c == 32'd0) || (norm_c < 32'(cfg.tol));
        end
        valid_next = (cmd.op == OP_EMIT) || (cmd.op == OP_REJECT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            skip_reg  <= skip_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_SQ:     sq_reg <= sq_full;
            OP_ACC_SQ: sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
            OP_SQRT:
            begin
                x_reg    <= xs << 2;
                rem_reg  <= sq_ge ? 34'(remsh - trial) : remsh[33:0];
                root_reg <= {rt[30:0], sq_ge};
            end
            OP_NORM:   norm_reg <= norm_c;
            OP_DIV:
            begin
                if (cmd.first)
                begin
                    neg_reg <= w_rd[31];
                end
                dq_reg   <= {dsrc[NUM_W-2:0], d_ge};
                drem_reg <= d_ge ? 32'(dsh - {1'b0, norm_reg}) : dsh[31:0];
            end
            OP_MUL_QW: prod_reg <= $signed(q_rd) * $signed(w_rd);
            OP_ACC_P:  acc_reg <= (cmd.first ? 64'sd0 : acc_reg) + prod_reg;
            OP_RKJ:    rkj_reg <= rkj_c;
            OP_MUL_QR: prod_reg <= $signed(q_rd) * $signed(rkj_reg);
            OP_EMIT:
            begin
                value_reg  <= cmd.mat ? (lower ? 32'd0 : r_rd) : q_rd;
                which_reg  <= cmd.mat;
                row_reg    <= cmd.row[2:0];
                col_reg    <= cmd.wcol[1:0];
                last_reg   <= cmd.last;
                status_reg <= 1'b0;
            end
            OP_REJECT:
            begin
                value_reg  <= 32'd0;
                which_reg  <= 1'b0;
                row_reg    <= 3'd0;
                col_reg    <= 2'd0;
                last_reg   <= 1'b1;
                status_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign stat.skip     = skip_reg;
    assign result_valid  = valid_reg;
    assign result_value  = value_reg;
    assign which_matrix  = which_reg;
    assign row_index     = row_reg;
    assign col_index     = col_reg;
    assign last_result   = last_reg;
    assign status        = status_reg;

endmodule

// File: src/qr_modified_gram_schmidt_core.sv
// ----------------------------------------------------------------------------
// qr_modified_gram_schmidt_core: fixed-point QR by modified Gram-Schmidt
// Load: one element per cycle in idle with start high. Per column k: norm (serial
// root), serial divide (skipped if norm zero or below tol), later columns updated.
// Results cannot be stalled; reset clears control and restores config defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "qr_modified_gram_schmidt_core_defines.svh"

module qr_modified_gram_schmidt_core #(
    parameter int MAX_ROWS  = 8,
    parameter int MAX_COLS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] element_value,
    input  logic               last_element,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    output logic               result_valid,
    output logic signed [31:0] result_value,
    output logic               which_matrix,
    output logic [2:0]         row_index,
    output logic [1:0]         col_index,
    output logic               last_result,
    output logic               status
);

    import qrmgs_pkg::*;

    logic [3:0]  rows_reg, rows_next;
    logic [2:0]  cols_reg, cols_next;
    logic [15:0] tol_reg, tol_next;
    cfg_t        cfg;
    stat_t       stat;
    cmd_t        cmd;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        tol_next  = tol_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROWS: rows_next = cfg_wdata[3:0];
                CFG_COLS: cols_next = cfg_wdata[2:0];
                CFG_TOL:  tol_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 4'd8;
            cols_reg <= 3'd4;
            tol_reg  <= 16'd1;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            tol_reg  <= tol_next;
        end
    end

    // clamp the dimensions into 1..MAX
    always_comb
    begin
        cfg.rows = (rows_reg == 4'd0) ? ROW_FW'(1) :
                   (ROW_FW'(rows_reg) > ROW_FW'(MAX_ROWS)) ? ROW_FW'(MAX_ROWS) :
                   ROW_FW'(rows_reg);
        cfg.cols = (cols_reg == 3'd0) ? COL_FW'(1) :
                   (COL_FW'(cols_reg) > COL_FW'(MAX_COLS)) ? COL_FW'(MAX_COLS) :
                   COL_FW'(cols_reg);
        cfg.tol  = tol_reg;
    end

    qrmgs_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .last_element (last_element),
        .cfg          (cfg),
        .stat         (stat),
        .busy         (busy),
        .cmd          (cmd)
    );

    qrmgs_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .element_value (element_value),
        .stat          (stat),
        .result_valid  (result_valid),
        .result_value  (result_value),
        .which_matrix  (which_matrix),
        .row_index     (row_index),
        .col_index     (col_index),
        .last_result   (last_result),
        .status        (status)
    );

    `QRMGS_ASSERT_IMP(a_reject_beat, result_valid && status, last_result && (result_value == 32'sd0))
    `QRMGS_ASSERT_NXT(a_gap_after_last, result_valid && last_result, !result_valid)
    `QRMGS_ASSERT_NXT(a_run_starts, start && !busy && last_element, busy)
    `QRMGS_ASSERT_IMP(a_r_lower_zero, result_valid && which_matrix && (row_index > {1'b0, col_index}), result_value == 32'sd0)

endmodule
